// ===== sv/nfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfp_pkg: shared types and constants of the Newton fractal pixel iterator
// Holds the transaction structs, configuration layout, datapath command set
// and the micro-program of one Newton step.
// ----------------------------------------------------------------------------
package nfp_pkg;

	localparam int BAILOUT_DEF   = 16;
	localparam int FRAC_BITS_DEF = 28;

	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;
	localparam int CNT_W  = 16;
	localparam int PC_W   = 4;
	localparam int CMP_W  = 96;

	localparam logic [63:0]      COEF3_RST = 64'h1000_0000_0000_0000;
	localparam logic [63:0]      COEF0_RST = 64'hF000_0000_0000_0000;
	localparam logic [63:0]      RELAX_RST = 64'h1000_0000_0000_0000;
	localparam logic [CNT_W-1:0] LIMIT_RST = 16'd256;
	localparam logic [1:0]       MODE_RST  = 2'b10;

	typedef enum logic [2:0] {
		REG_COEF3 = 3'd0,
		REG_COEF2 = 3'd1,
		REG_COEF1 = 3'd2,
		REG_COEF0 = 3'd3,
		REG_RELAX = 3'd4,
		REG_START = 3'd5,
		REG_LIMIT = 3'd6,
		REG_MODE  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] re;
		logic signed [31:0] im;
	} cpx_t;

	typedef struct packed {
		logic signed [31:0] pixel_re;
		logic signed [31:0] pixel_im;
	} pixel_t;

	typedef struct packed {
		logic               status;
		logic [CNT_W-1:0]   iterations;
		logic signed [31:0] newest_re;
		logic signed [31:0] newest_im;
		logic signed [31:0] middle_re;
		logic signed [31:0] middle_im;
		logic signed [31:0] oldest_re;
		logic signed [31:0] oldest_im;
	} result_t;

	typedef struct packed {
		cpx_t a3;
		cpx_t a2;
		cpx_t a1;
		cpx_t a0;
		cpx_t rel;
		cpx_t start_pt;
		logic nova;
		logic from_pixel;
	} cfg_t;

	typedef enum logic [2:0] {
		OP_INIT,
		OP_CADD,
		OP_CSUB,
		OP_CMUL,
		OP_DIV,
		OP_PUSH,
		OP_CONV
	} op_t;

	typedef enum logic [3:0] {
		SEL_Z,
		SEL_T,
		SEL_Q,
		SEL_C,
		SEL_F,
		SEL_D,
		SEL_A3,
		SEL_A2,
		SEL_A1,
		SEL_A0,
		SEL_R,
		SEL_D0,
		SEL_D1,
		SEL_D2
	} sel_t;

	typedef struct packed {
		logic valid;
		op_t  op;
		sel_t a;
		sel_t b;
		sel_t dst;
	} cmd_t;

	typedef struct packed {
		logic done;
		logic conv;
		logic d_zero;
	} dp_status_t;

	typedef struct packed {
		op_t  op;
		sel_t a;
		sel_t b;
		sel_t dst;
		logic nova_only;
		logic zero_check;
		logic last;
	} prog_t;

	// One Newton step: Horner for p and p', zero test, divide, relax, nova add,
	// shift the orbit, convergence test.
	function automatic prog_t prog_entry(input logic [PC_W-1:0] pc);
		prog_t e;
		unique case (pc)
			4'd0:    e = '{OP_CMUL, SEL_A3, SEL_Z,  SEL_T, 1'b0, 1'b0, 1'b0};
			4'd1:    e = '{OP_CADD, SEL_T,  SEL_A2, SEL_T, 1'b0, 1'b0, 1'b0};
			4'd2:    e = '{OP_CMUL, SEL_T,  SEL_Z,  SEL_T, 1'b0, 1'b0, 1'b0};
			4'd3:    e = '{OP_CADD, SEL_T,  SEL_A1, SEL_T, 1'b0, 1'b0, 1'b0};
			4'd4:    e = '{OP_CMUL, SEL_T,  SEL_Z,  SEL_T, 1'b0, 1'b0, 1'b0};
			4'd5:    e = '{OP_CADD, SEL_T,  SEL_A0, SEL_F, 1'b0, 1'b0, 1'b0};
			4'd6:    e = '{OP_CMUL, SEL_D0, SEL_Z,  SEL_T, 1'b0, 1'b0, 1'b0};
			4'd7:    e = '{OP_CADD, SEL_T,  SEL_D1, SEL_T, 1'b0, 1'b0, 1'b0};
			4'd8:    e = '{OP_CMUL, SEL_T,  SEL_Z,  SEL_T, 1'b0, 1'b0, 1'b0};
			4'd9:    e = '{OP_CADD, SEL_T,  SEL_D2, SEL_D, 1'b0, 1'b0, 1'b0};
			4'd10:   e = '{OP_DIV,  SEL_F,  SEL_D,  SEL_Q, 1'b0, 1'b1, 1'b0};
			4'd11:   e = '{OP_CMUL, SEL_R,  SEL_Q,  SEL_T, 1'b0, 1'b0, 1'b0};
			4'd12:   e = '{OP_CSUB, SEL_Z,  SEL_T,  SEL_T, 1'b0, 1'b0, 1'b0};
			4'd13:   e = '{OP_CADD, SEL_T,  SEL_C,  SEL_T, 1'b1, 1'b0, 1'b0};
			4'd14:   e = '{OP_PUSH, SEL_T,  SEL_T,  SEL_Z, 1'b0, 1'b0, 1'b0};
			default: e = '{OP_CONV, SEL_Z,  SEL_Z,  SEL_Z, 1'b0, 1'b0, 1'b1};
		endcase
		return e;
	endfunction

endpackage

// ===== sv/nfp_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfp_div: radix-2 fixed-point divider
// Computes round(mag * 2^F / den) with sign, saturated to 32 bits, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module nfp_div import nfp_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [63:0]        mag,
	input  logic               neg,
	input  logic [63:0]        den,
	output logic               done,
	output logic signed [31:0] quo
);

	localparam int SH = 31 - FRAC_BITS;
	localparam int QB = 32;
	localparam int CW = $clog2(QB + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [63:0]   rem_q;
	logic [31:0]   nlo_q;
	logic [31:0]   qacc_q;
	logic [63:0]   den_q;
	logic          neg_q;
	logic          sat_q;

	logic [64:0] rem2;
	logic        ge;
	logic [64:0] rem_sub;
	logic [32:0] qr;
	logic        big;
	logic        sat_c;

	assign sat_c   = {{SH{1'b0}}, mag} >= {den, {SH{1'b0}}};
	assign rem2    = {rem_q, nlo_q[31]};
	assign ge      = rem2 >= {1'b0, den_q};
	assign rem_sub = rem2 - {1'b0, den_q};
	assign done    = busy_q && (cnt_q == CW'(QB));

	// round half up on the extra quotient bit
	assign qr  = ({1'b0, qacc_q} + 33'd1) >> 1;
	assign big = sat_q || qr[31];

	always_comb begin
		if (big)
			quo = neg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		else if (neg_q)
			quo = -$signed(qr[31:0]);
		else
			quo = $signed(qr[31:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= mag >> SH;
			nlo_q  <= mag[31:0] << (FRAC_BITS + 1);
			qacc_q <= '0;
			den_q  <= den;
			neg_q  <= neg;
			sat_q  <= sat_c;
		end else if (busy_q && !done) begin
			rem_q  <= ge ? rem_sub[63:0] : rem2[63:0];
			nlo_q  <= {nlo_q[30:0], 1'b0};
			qacc_q <= {qacc_q[30:0], ge};
		end
	end

endmodule

// ===== sv/nfp_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfp_datapath: complex arithmetic datapath
// Orbit and work registers, one shared 33x33 multiplier, saturating complex
// add, divide by the derivative and the convergence test.
// ----------------------------------------------------------------------------
module nfp_datapath import nfp_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int BAILOUT   = BAILOUT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  pixel_t     pixel,
	input  cmd_t       cmd,
	output dp_status_t dp_status,
	output cpx_t       newest,
	output cpx_t       middle,
	output cpx_t       oldest
);

	localparam int ACC_W = 66 - FRAC_BITS;
	localparam logic signed [65:0] HALF    = 66'sd1 <<< (FRAC_BITS - 1);
	localparam logic [63:0]        ONE     = 64'd1 << (2 * FRAC_BITS);
	localparam logic signed [32:0] BAIL_OP = 33'(BAILOUT);

	function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
		if (v[32] != v[31])
			return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
		if (v[33:31] != {3{v[33]}})
			return v[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] sat_acc(input logic signed [ACC_W-1:0] v);
		if (v[ACC_W-1:31] != {(ACC_W - 31){v[ACC_W-1]}})
			return v[ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		return v[31:0];
	endfunction

	cpx_t z_q, z1_q, z2_q, c_q, t_q, f_q, d_q, q_q;
	cpx_t opa_q, opb_q;
	sel_t dst_q;
	op_t  op_q;
	logic active_q;
	logic [3:0] ph_q;

	logic signed [65:0]      prod_q;
	logic signed [ACC_W-1:0] acc_re_q, acc_im_q;
	logic [63:0]             den_q, d2_q, m_q;
	logic signed [64:0]      nre_q, nim_q;
	logic [CMP_W-1:0]        bm_q;

	cpx_t d0, d1, d2c, z0, diffz;
	cpx_t sum_c, sub_c, cm_c, wr_val;
	logic signed [32:0] mul_x, mul_y;
	logic signed [65:0] rnd_full;
	logic signed [ACC_W-1:0] rnd;
	logic [CMP_W-1:0] d2_sh, prod_ext;
	logic signed [64:0] nre_abs, nim_abs;
	logic wr_en, done_c, hold_c, conv_c;
	logic div_start, div_neg, div_done;
	logic [63:0] div_mag;
	logic signed [31:0] div_quo;

	// derivative coefficients follow the coefficient registers
	assign d0.re  = sat34((34'(cfg.a3.re) <<< 1) + 34'(cfg.a3.re));
	assign d0.im  = sat34((34'(cfg.a3.im) <<< 1) + 34'(cfg.a3.im));
	assign d1.re  = sat34(34'(cfg.a2.re) <<< 1);
	assign d1.im  = sat34(34'(cfg.a2.im) <<< 1);
	assign d2c    = cfg.a1;
	assign z0     = cfg.from_pixel ? cpx_t'({pixel.pixel_re, pixel.pixel_im}) : cfg.start_pt;

	assign sum_c.re = sat33(33'(opa_q.re) + 33'(opb_q.re));
	assign sum_c.im = sat33(33'(opa_q.im) + 33'(opb_q.im));
	assign sub_c.re = sat33(33'(opa_q.re) - 33'(opb_q.re));
	assign sub_c.im = sat33(33'(opa_q.im) - 33'(opb_q.im));
	assign diffz.re = sat33(33'(z_q.re) - 33'(z1_q.re));
	assign diffz.im = sat33(33'(z_q.im) - 33'(z1_q.im));
	assign cm_c.re  = sat_acc(acc_re_q);
	assign cm_c.im  = sat_acc(acc_im_q);

	assign rnd_full = (prod_q + HALF) >>> FRAC_BITS;
	assign rnd      = rnd_full[ACC_W-1:0];
	assign prod_ext = {{(CMP_W - 64){1'b0}}, prod_q[63:0]};
	assign d2_sh    = {{(CMP_W - 64){1'b0}}, d2_q} << FRAC_BITS;
	assign nre_abs  = nre_q[64] ? -nre_q : nre_q;
	assign nim_abs  = nim_q[64] ? -nim_q : nim_q;

	function automatic cpx_t pick(input sel_t s);
		cpx_t v;
		unique case (s)
			SEL_Z:   v = z_q;
			SEL_T:   v = t_q;
			SEL_Q:   v = q_q;
			SEL_C:   v = c_q;
			SEL_F:   v = f_q;
			SEL_D:   v = d_q;
			SEL_A3:  v = cfg.a3;
			SEL_A2:  v = cfg.a2;
			SEL_A1:  v = cfg.a1;
			SEL_A0:  v = cfg.a0;
			SEL_R:   v = cfg.rel;
			SEL_D0:  v = d0;
			SEL_D1:  v = d1;
			SEL_D2:  v = d2c;
			default: v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		mul_x     = '0;
		mul_y     = '0;
		wr_en     = 1'b0;
		wr_val    = sum_c;
		done_c    = 1'b0;
		hold_c    = 1'b0;
		conv_c    = 1'b0;
		div_start = 1'b0;
		div_mag   = nre_abs[63:0];
		div_neg   = nre_q[64];
		if (active_q) begin
			unique case (op_q)
				OP_CADD: begin
					wr_en  = 1'b1;
					done_c = 1'b1;
				end
				OP_CSUB: begin
					wr_en  = 1'b1;
					wr_val = sub_c;
					done_c = 1'b1;
				end
				OP_CMUL: begin
					case (ph_q)
						4'd0: begin mul_x = 33'(opa_q.re); mul_y = 33'(opb_q.re); end
						4'd1: begin mul_x = 33'(opa_q.im); mul_y = 33'(opb_q.im); end
						4'd2: begin mul_x = 33'(opa_q.re); mul_y = 33'(opb_q.im); end
						4'd3: begin mul_x = 33'(opa_q.im); mul_y = 33'(opb_q.re); end
						4'd5: begin
							wr_en  = 1'b1;
							wr_val = cm_c;
							done_c = 1'b1;
						end
						default: ;
					endcase
				end
				OP_DIV: begin
					case (ph_q)
						4'd0: begin mul_x = 33'(d_q.re); mul_y = 33'(d_q.re); end
						4'd1: begin mul_x = 33'(d_q.im); mul_y = 33'(d_q.im); end
						4'd2: begin mul_x = 33'(f_q.re); mul_y = 33'(d_q.re); end
						4'd3: begin mul_x = 33'(f_q.im); mul_y = 33'(d_q.im); end
						4'd4: begin mul_x = 33'(f_q.im); mul_y = 33'(d_q.re); end
						4'd5: begin mul_x = 33'(f_q.re); mul_y = 33'(d_q.im); end
						4'd7: div_start = 1'b1;
						4'd8: hold_c = !div_done;
						4'd9: begin
							div_start = 1'b1;
							div_mag   = nim_abs[63:0];
							div_neg   = nim_q[64];
						end
						4'd10: begin
							hold_c = !div_done;
							done_c = div_done;
						end
						default: ;
					endcase
				end
				OP_PUSH: done_c = 1'b1;
				OP_CONV: begin
					case (ph_q)
						4'd0: begin mul_x = 33'(diffz.re); mul_y = 33'(diffz.re); end
						4'd1: begin mul_x = 33'(diffz.im); mul_y = 33'(diffz.im); end
						4'd2: begin mul_x = 33'(z_q.re); mul_y = 33'(z_q.re); end
						4'd3: begin mul_x = 33'(z_q.im); mul_y = 33'(z_q.im); end
						4'd6: begin mul_x = BAIL_OP; mul_y = $signed({1'b0, m_q[31:0]}); end
						4'd7: begin mul_x = BAIL_OP; mul_y = $signed({1'b0, m_q[63:32]}); end
						4'd9: begin
							done_c = 1'b1;
							conv_c = d2_sh <= bm_q;
						end
						default: ;
					endcase
				end
				default: done_c = 1'b1;
			endcase
		end
	end

	nfp_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.mag   (div_mag),
		.neg   (div_neg),
		.den   (den_q),
		.done  (div_done),
		.quo   (div_quo)
	);

	// sequencing of the multi-cycle operations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			ph_q     <= '0;
			op_q     <= OP_INIT;
		end else if (cmd.valid && cmd.op != OP_INIT) begin
			active_q <= 1'b1;
			ph_q     <= '0;
			op_q     <= cmd.op;
		end else if (active_q) begin
			if (done_c)
				active_q <= 1'b0;
			else if (!hold_c)
				ph_q <= ph_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_x * mul_y;
		if (cmd.valid) begin
			opa_q <= pick(cmd.a);
			opb_q <= pick(cmd.b);
			dst_q <= cmd.dst;
			if (cmd.op == OP_INIT) begin
				c_q  <= cpx_t'({pixel.pixel_re, pixel.pixel_im});
				z_q  <= z0;
				z1_q <= z0;
				z2_q <= z0;
			end
		end
		if (wr_en) begin
			case (dst_q)
				SEL_T:   t_q <= wr_val;
				SEL_F:   f_q <= wr_val;
				SEL_D:   d_q <= wr_val;
				default: ;
			endcase
		end
		if (active_q) begin
			case (op_q)
				OP_CMUL: begin
					case (ph_q)
						4'd1: acc_re_q <= rnd;
						4'd2: acc_re_q <= acc_re_q - rnd;
						4'd3: acc_im_q <= rnd;
						4'd4: acc_im_q <= acc_im_q + rnd;
						default: ;
					endcase
				end
				OP_DIV: begin
					case (ph_q)
						4'd1: den_q <= prod_q[63:0];
						4'd2: den_q <= den_q + prod_q[63:0];
						4'd3: nre_q <= prod_q[64:0];
						4'd4: nre_q <= nre_q + prod_q[64:0];
						4'd5: nim_q <= prod_q[64:0];
						4'd6: nim_q <= nim_q - prod_q[64:0];
						4'd8: if (div_done) q_q.re <= div_quo;
						4'd10: if (div_done) q_q.im <= div_quo;
						default: ;
					endcase
				end
				OP_PUSH: begin
					z2_q <= z1_q;
					z1_q <= z_q;
					z_q  <= opa_q;
				end
				OP_CONV: begin
					case (ph_q)
						4'd1: d2_q <= prod_q[63:0];
						4'd2: d2_q <= d2_q + prod_q[63:0];
						4'd3: m_q  <= prod_q[63:0];
						4'd4: m_q  <= m_q + prod_q[63:0];
						4'd5: if (m_q < ONE) m_q <= ONE;
						4'd7: bm_q <= prod_ext;
						4'd8: bm_q <= bm_q + (prod_ext << 32);
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	assign dp_status.done   = done_c;
	assign dp_status.conv   = conv_c;
	assign dp_status.d_zero = (d_q == '0);
	assign newest = z_q;
	assign middle = z1_q;
	assign oldest = z2_q;

endmodule

// ===== sv/nfp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfp_ctrl: iteration controller
// Steps through the Newton micro-program, counts steps and decides when a
// pixel is finished.
// ----------------------------------------------------------------------------
module nfp_ctrl import nfp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [CNT_W-1:0] iteration_limit,
	input  logic             nova,
	input  dp_status_t       dp_status,
	output cmd_t             cmd,
	output logic             busy,
	output logic             done,
	output logic             status,
	output logic [CNT_W-1:0] iterations
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_ISSUE  = 4'b0010,
		S_WAIT   = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t           state_q, state_d;
	logic [PC_W-1:0]  pc_q, pc_d;
	logic [CNT_W-1:0] count_q, count_d, count_inc;
	logic             status_q, status_d;
	prog_t            entry;

	assign entry     = prog_entry(pc_q);
	assign count_inc = count_q + 1'b1;

	always_comb begin
		state_d  = state_q;
		pc_d     = pc_q;
		count_d  = count_q;
		status_d = status_q;
		cmd      = '{1'b0, entry.op, entry.a, entry.b, entry.dst};
		unique case (state_q)
			S_IDLE: begin
				cmd = '{start, OP_INIT, SEL_Z, SEL_Z, SEL_Z};
				if (start) begin
					pc_d     = '0;
					count_d  = '0;
					status_d = 1'b0;
					state_d  = (iteration_limit == '0) ? S_FINISH : S_ISSUE;
				end
			end
			S_ISSUE: begin
				if (entry.zero_check && dp_status.d_zero) begin
					status_d = 1'b1;
					state_d  = S_FINISH;
				end else if (entry.nova_only && !nova) begin
					pc_d = pc_q + 1'b1;
				end else begin
					cmd.valid = 1'b1;
					state_d   = S_WAIT;
				end
			end
			S_WAIT: begin
				if (dp_status.done) begin
					if (entry.last) begin
						count_d = count_inc;
						pc_d    = '0;
						state_d = (dp_status.conv || count_inc == iteration_limit) ?
							S_FINISH : S_ISSUE;
					end else begin
						pc_d    = pc_q + 1'b1;
						state_d = S_ISSUE;
					end
				end
			end
			S_FINISH: state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			pc_q     <= '0;
			count_q  <= '0;
			status_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			pc_q     <= pc_d;
			count_q  <= count_d;
			status_q <= status_d;
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = (state_q == S_FINISH);
	assign status     = status_q;
	assign iterations = count_q;

endmodule

// ===== sv/newton_fractal_pixel_iterator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// newton_fractal_pixel_iterator: relaxed Newton iteration for one pixel
// Configuration registers, iteration controller and complex datapath.
// ----------------------------------------------------------------------------
// A pixel transaction is taken when start is high while busy is low; busy
// then stays high until the result has been shown. The result appears on
// result for exactly one cycle with done high: capture it in that cycle.
// The run time of a Newton step is set by the single shared 33x33
// multiplier (six complex products per step) and by the radix-2 divider,
// which runs twice per step. A step without the nova add is shorter; the
// default limit is 256 steps. Registers sit on a 64-bit APB-style port at
// byte address 8 * index; write them only while busy is low. The
// derivative of the polynomial follows the coefficient registers without a
// separate update step.
// ----------------------------------------------------------------------------
module newton_fractal_pixel_iterator import nfp_pkg::*; #(
	parameter int BAILOUT   = BAILOUT_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              start,
	output logic              busy,
	input  pixel_t            pixel,
	output logic              done,
	output result_t           result
);

	logic [63:0]      coef3_q, coef2_q, coef1_q, coef0_q, relax_q, start_q;
	logic [CNT_W-1:0] limit_q;
	logic [1:0]       mode_q;

	logic       cfg_wr;
	reg_idx_t   reg_idx;
	cfg_t       cfg;
	cmd_t       cmd;
	dp_status_t dp_status;
	cpx_t       newest, middle, oldest;
	logic       status;
	logic [CNT_W-1:0] iterations;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:3]);

	// register file: write in the access phase, bits beyond a register's
	// width drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef3_q <= COEF3_RST;
			coef2_q <= '0;
			coef1_q <= '0;
			coef0_q <= COEF0_RST;
			relax_q <= RELAX_RST;
			start_q <= '0;
			limit_q <= LIMIT_RST;
			mode_q  <= MODE_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_COEF3: coef3_q <= pwdata;
				REG_COEF2: coef2_q <= pwdata;
				REG_COEF1: coef1_q <= pwdata;
				REG_COEF0: coef0_q <= pwdata;
				REG_RELAX: relax_q <= pwdata;
				REG_START: start_q <= pwdata;
				REG_LIMIT: limit_q <= pwdata[CNT_W-1:0];
				REG_MODE:  mode_q  <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_COEF3: prdata = coef3_q;
			REG_COEF2: prdata = coef2_q;
			REG_COEF1: prdata = coef1_q;
			REG_COEF0: prdata = coef0_q;
			REG_RELAX: prdata = relax_q;
			REG_START: prdata = start_q;
			REG_LIMIT: prdata = {{(DATA_W - CNT_W){1'b0}}, limit_q};
			REG_MODE:  prdata = {{(DATA_W - 2){1'b0}}, mode_q};
			default:   prdata = '0;
		endcase
	end

	// mode bit 0 adds the pixel each step, bit 1 starts the orbit at the pixel
	assign cfg.a3         = cpx_t'(coef3_q);
	assign cfg.a2         = cpx_t'(coef2_q);
	assign cfg.a1         = cpx_t'(coef1_q);
	assign cfg.a0         = cpx_t'(coef0_q);
	assign cfg.rel        = cpx_t'(relax_q);
	assign cfg.start_pt   = cpx_t'(start_q);
	assign cfg.nova       = mode_q[0];
	assign cfg.from_pixel = mode_q[1];

	nfp_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.iteration_limit(limit_q),
		.nova           (mode_q[0]),
		.dp_status      (dp_status),
		.cmd            (cmd),
		.busy           (busy),
		.done           (done),
		.status         (status),
		.iterations     (iterations)
	);

	nfp_datapath #(
		.FRAC_BITS(FRAC_BITS),
		.BAILOUT  (BAILOUT)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.pixel    (pixel),
		.cmd      (cmd),
		.dp_status(dp_status),
		.newest   (newest),
		.middle   (middle),
		.oldest   (oldest)
	);

	// orbit registers hold still while the result is shown
	assign result.status     = status;
	assign result.iterations = iterations;
	assign result.newest_re  = newest.re;
	assign result.newest_im  = newest.im;
	assign result.middle_re  = middle.re;
	assign result.middle_im  = middle.im;
	assign result.oldest_re  = oldest.re;
	assign result.oldest_im  = oldest.im;

endmodule

// ===== sv/nfp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfp_checker: port-level checks of the pixel iterator
// Watches the command handshake and the result strobe.
// ----------------------------------------------------------------------------
module nfp_checker import nfp_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    done,
	input logic    pready,
	input result_t result
);

	// a result never shows while the block is idle
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe while idle");

	// an accepted transaction makes the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("transaction accepted but block not busy");

	// the strobe lasts one cycle and frees the block
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!busy && !done))
		else $error("block still busy after result");

	// a zero-derivative stop cannot have reached the step count maximum
	a_status_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status) |-> (result.iterations != 16'hFFFF))
		else $error("zero-derivative stop after full step count");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind newton_fractal_pixel_iterator nfp_checker u_nfp_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.pready(pready),
	.result(result)
);
